### hdl/trsp_pkg.sv
package trsp_pkg;

    // Default fraction bits of the fixed-point coordinates
    localparam int FRAC_BITS_DEF = 16;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Result slots, in emission order
    localparam logic [2:0] SLOT_INV      = 3'd0;
    localparam logic [2:0] SLOT_COEF_LO  = 3'd1;
    localparam logic [2:0] SLOT_COEF_HI  = 3'd2;
    localparam logic [2:0] SLOT_CORNER_A = 3'd3;
    localparam logic [2:0] SLOT_CORNER_B = 3'd4;
    localparam logic [2:0] SLOT_CORNER_C = 3'd5;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    // Classified triangle: edge magnitudes relative to corner A
    typedef struct packed {
        logic [2:0][15:0] idx;     // vertex indices A, B, C
        logic [2:0]       dot_neg; // sign of AB(i)*AC(i) product
        logic [2:0][31:0] ab_mag;  // |B - A| per axis, saturated
        logic [2:0][31:0] ac_mag;  // |C - A| per axis, saturated
    } trsp_tri_t;

    // Finished triangle handed from the back end to the output stage
    typedef struct packed {
        logic [31:0]      q_v;     // |V|/det, saturated magnitude
        logic [31:0]      q_lu;    // |L-U|/det
        logic [31:0]      q_u;     // |U|/det
        logic [31:0]      q_l;     // L/det
        logic             lu_neg;  // L-U is negative
        logic             u_neg;   // U is negative
        logic [31:0]      det_f;
        logic [31:0]      area_f;
        logic [31:0]      share;
        logic [2:0][31:0] nrm_x;   // corner normals A, B, C
        logic [2:0][31:0] nrm_y;
        logic [2:0][15:0] idx;
        logic             degen;
    } trsp_rec_t;

endpackage

### hdl/triangle_rest_shape_precompute_unit.sv
// Triangle rest-shape precompute.
// Input stream s_*: one beat is one triangle, three vertices in signed fixed
// point and three vertex indices. Output stream m_*: six beats per triangle,
// slots 0 to 5 in order (inverse rest matrix, shape coefficients, det and
// area, then corners A, B, C with mass share and normal); m_tlast marks slot 5.
// cfg_wr_en/cfg_wr_data load mass_per_area; write it only while idle.
// Each triangle passes through the shared one-bit-per-cycle divider, DW =
// max(64, 34 + 2*FRAC_BITS) bits wide, which does the projection and four
// quotients, and through three 32-step square roots and the mass share.
// Zero-magnitude quotients and a zero determinant skip the divider.
// The back end takes one triangle at a time, and the six output beats overlap
// the next triangle's computation. A two-entry queue behind the input
// register keeps accepting triangles while the back end works.
// Reset (aresetn low, synchronous) empties queue and output and clears
// mass_per_area. When m_tready is low the current beat holds and the
// back end finishes its triangle, then waits.
module triangle_rest_shape_precompute_unit #(
    parameter int FRAC_BITS = trsp_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,   // mass_per_area
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, a_index, b_index, c_index
    input  logic [335:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_index, value0, value1, value2, value3
    output logic [143:0] m_tdata,
    // slot, degenerate
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    logic                push, full, pop, not_empty, rec_valid, rec_ready;
    trsp_pkg::trsp_tri_t push_data, pop_data;
    trsp_pkg::trsp_rec_t rec;

    trsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    trsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    trsp_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tri_valid   (not_empty),
        .tri_data    (pop_data),
        .tri_pop     (pop),
        .rec_valid   (rec_valid),
        .rec         (rec),
        .rec_ready   (rec_ready)
    );

    trsp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### hdl/trsp_fifo.sv
module trsp_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  trsp_pkg::trsp_tri_t push_data,
    output logic                full,
    input  logic                pop,
    output trsp_pkg::trsp_tri_t pop_data,
    output logic                not_empty
);

    localparam int PW = trsp_pkg::FIFO_PTR_W;
    localparam int DEPTH = trsp_pkg::FIFO_DEPTH;

    trsp_pkg::trsp_tri_t     mem_reg [DEPTH];
    logic [PW-1:0]           wr_ptr_reg;
    logic [PW-1:0]           rd_ptr_reg;
    logic [$clog2(DEPTH+1)-1:0] count_reg;

    assign full      = (count_reg == ($clog2(DEPTH+1))'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && not_empty)) begin
                count_reg <= count_reg + 1'b1;
            end else if (!(push && !full) && (pop && not_empty)) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/trsp_front.sv
module trsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [335:0]         s_tdata,
    output logic                 push,
    output trsp_pkg::trsp_tri_t  push_data,
    input  logic                 full
);

    logic                hold_valid_reg;
    trsp_pkg::trsp_tri_t hold_reg;
    trsp_pkg::trsp_tri_t cls;

    assign s_tready  = !hold_valid_reg || !full;
    assign push      = hold_valid_reg;
    assign push_data = hold_reg;

    // Classify: saturated edge differences, magnitudes and dot signs
    always_comb begin
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [32:0] db;
        logic signed [32:0] dc;
        logic [31:0]        sb;
        logic [31:0]        sc;
        cls = '0;
        for (int i = 0; i < 3; i++) begin
            a  = s_tdata[32*i +: 32];
            b  = s_tdata[96 + 32*i +: 32];
            c  = s_tdata[192 + 32*i +: 32];
            db = $signed({b[31], b}) - $signed({a[31], a});
            dc = $signed({c[31], c}) - $signed({a[31], a});
            if (db[32] != db[31]) sb = db[32] ? trsp_pkg::NEG_LIMIT : trsp_pkg::POS_LIMIT;
            else                  sb = db[31:0];
            if (dc[32] != dc[31]) sc = dc[32] ? trsp_pkg::NEG_LIMIT : trsp_pkg::POS_LIMIT;
            else                  sc = dc[31:0];
            cls.ab_mag[i]  = sb[31] ? 32'(32'd0 - sb) : sb;
            cls.ac_mag[i]  = sc[31] ? 32'(32'd0 - sc) : sc;
            cls.dot_neg[i] = sb[31] ^ sc[31];
            cls.idx[i]     = s_tdata[288 + 16*i +: 16];
        end
    end

    // Hold one classified beat until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tready) begin
            hold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_reg <= cls;
        end
    end

endmodule

### hdl/trsp_div.sv
module trsp_div #(
    parameter int DW = 66
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [63:0]   divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [63:0]   rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] quo_reg;
    logic [63:0]   dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [64:0]   trial;
    logic          take;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign take  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(DW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= take ? 64'(trial - {1'b0, dsr_reg}) : trial[63:0];
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], take};
        end
    end

endmodule

### hdl/trsp_core.sv
module trsp_core #(
    parameter int FRAC_BITS = trsp_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                tri_valid,
    input  trsp_pkg::trsp_tri_t tri_data,
    output logic                tri_pop,
    output logic                rec_valid,
    output trsp_pkg::trsp_rec_t rec,
    input  logic                rec_ready
);

    localparam int DW = (34 + 2 * FRAC_BITS > 64) ? 34 + 2 * FRAC_BITS : 64;
    localparam int SH_BITS = 2 * FRAC_BITS + 1;

    // ceil(2^45 / 100): exact floor division by 100 for dividends below 2^38
    localparam logic [31:0] RCP100_LO = 32'hEB85_1EB9;
    localparam logic [31:0] RCP100_HI = 32'h0000_0051;

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_SQAB, S_SQAC, S_USTART, S_UWAIT, S_UMUL, S_SQV,
        S_DMUL, S_SMUL, S_SSTART, S_SRCP, S_QSTART, S_QWAIT, S_DONE
    } state_t;

    state_t              state_reg;
    logic [5:0]          cnt_reg;
    logic [1:0]          qsel_reg;
    trsp_pkg::trsp_tri_t ent_reg;
    logic [31:0]         mpa_reg;

    logic [63:0]  lab2_reg, lac2_reg, dpos_reg, dneg_reg, rad_reg, det_reg;
    logic [31:0]  lu_reg, lc_reg, um_reg, vu_reg, share_reg;
    logic [31:0]  qv_reg, qlu_reg, qu_reg, ql_reg;
    logic [101:0] sh_acc_reg;
    logic [76:0]  rcp_acc_reg;

    logic [63:0] sq_op_reg, sq_res_reg, sq_one_reg;
    logic [63:0] sq_sum, sq_src, sq_res_step;
    logic        sq_ge;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p_reg;

    logic          div_start, div_done;
    logic [DW-1:0] div_dvd, div_quo;
    logic [63:0]   div_dsr;

    logic          uneg, degen, lu_neg, sh_sat;
    logic [63:0]   dot_mag;
    logic [33:0]   lu_mag, qmag;
    logic [69:0]   a33;
    logic [101:0]  sh_t;
    logic [31:0]   qsat;
    logic [63:0]   det_sh, area_sh;
    logic [76:0]   rcp_sum;
    logic [31:0]   rcp_q;

    // Truncate a half toward zero and clamp to 32 bits
    function automatic logic [31:0] half_sat(input logic signed [35:0] x);
        logic signed [35:0] h;
        h = (x + $signed({35'd0, x[35]})) >>> 1;
        if (h > 36'sh0_7FFF_FFFF)       return trsp_pkg::POS_LIMIT;
        else if (h < -36'sh0_8000_0000) return trsp_pkg::NEG_LIMIT;
        else                            return h[31:0];
    endfunction

    // Derived triangle quantities
    assign uneg    = dneg_reg > dpos_reg;
    assign dot_mag = uneg ? dneg_reg - dpos_reg : dpos_reg - dneg_reg;
    assign degen   = (det_reg == '0);
    assign lu_neg  = !uneg && (um_reg > lu_reg);
    assign lu_mag  = uneg ? 34'(lu_reg) + 34'(um_reg) :
                     (lu_neg ? 34'(um_reg - lu_reg) : 34'(lu_reg - um_reg));
    assign a33     = {det_reg, 5'd0} + 70'(det_reg);
    assign sh_t    = sh_acc_reg >> SH_BITS;
    assign sh_sat  = |sh_t[101:38];
    assign qsat    = (|div_quo[DW-1:31]) ? trsp_pkg::NEG_LIMIT : div_quo[31:0];
    assign det_sh  = det_reg >> FRAC_BITS;
    assign area_sh = det_reg >> (FRAC_BITS + 1);

    // Mass share over 100: last partial product of the reciprocal, then drop 45 bits
    assign rcp_sum = rcp_acc_reg + {mul_p_reg[12:0], 64'd0};
    assign rcp_q   = rcp_sum[76:45];

    always_comb begin
        unique case (qsel_reg)
            2'd0:    qmag = 34'(vu_reg);
            2'd1:    qmag = lu_mag;
            2'd2:    qmag = 34'(um_reg);
            default: qmag = 34'(lu_reg);
        endcase
    end

    // Shared 32x32 multiplier, registered product
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PROD: begin
                unique case (cnt_reg)
                    6'd0:    begin mul_a = ent_reg.ab_mag[0]; mul_b = ent_reg.ab_mag[0]; end
                    6'd1:    begin mul_a = ent_reg.ab_mag[1]; mul_b = ent_reg.ab_mag[1]; end
                    6'd2:    begin mul_a = ent_reg.ab_mag[2]; mul_b = ent_reg.ab_mag[2]; end
                    6'd3:    begin mul_a = ent_reg.ac_mag[0]; mul_b = ent_reg.ac_mag[0]; end
                    6'd4:    begin mul_a = ent_reg.ac_mag[1]; mul_b = ent_reg.ac_mag[1]; end
                    6'd5:    begin mul_a = ent_reg.ac_mag[2]; mul_b = ent_reg.ac_mag[2]; end
                    6'd6:    begin mul_a = ent_reg.ab_mag[0]; mul_b = ent_reg.ac_mag[0]; end
                    6'd7:    begin mul_a = ent_reg.ab_mag[1]; mul_b = ent_reg.ac_mag[1]; end
                    6'd8:    begin mul_a = ent_reg.ab_mag[2]; mul_b = ent_reg.ac_mag[2]; end
                    default: ;
                endcase
            end
            S_UMUL: begin mul_a = um_reg; mul_b = um_reg; end
            S_DMUL: begin mul_a = lu_reg; mul_b = vu_reg; end
            S_SMUL: begin
                mul_b = mpa_reg;
                unique case (cnt_reg)
                    6'd0:    mul_a = a33[31:0];
                    6'd1:    mul_a = a33[63:32];
                    6'd2:    mul_a = 32'(a33[69:64]);
                    default: ;
                endcase
            end
            S_SRCP: begin
                unique case (cnt_reg)
                    6'd0:    begin mul_a = sh_t[31:0];         mul_b = RCP100_LO; end
                    6'd1:    begin mul_a = sh_t[31:0];         mul_b = RCP100_HI; end
                    6'd2:    begin mul_a = 32'(sh_t[37:32]);   mul_b = RCP100_LO; end
                    6'd3:    begin mul_a = 32'(sh_t[37:32]);   mul_b = RCP100_HI; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Square root, one result bit per cycle
    always_comb begin
        unique case (state_reg)
            S_SQAB:  sq_src = lab2_reg;
            S_SQAC:  sq_src = lac2_reg;
            default: sq_src = rad_reg;
        endcase
    end

    assign sq_sum      = sq_res_reg + sq_one_reg;
    assign sq_ge       = sq_op_reg >= sq_sum;
    assign sq_res_step = sq_ge ? (sq_res_reg >> 1) + sq_one_reg : sq_res_reg >> 1;

    // Divider operands
    always_comb begin
        div_start = 1'b0;
        div_dvd   = DW'(dot_mag);
        div_dsr   = 64'(lu_reg);
        unique case (state_reg)
            S_USTART: div_start = (lu_reg != '0);
            S_QSTART: begin
                div_start = (qmag != '0) && !degen;
                div_dvd   = DW'({qmag, {(2 * FRAC_BITS){1'b0}}});
                div_dsr   = det_reg;
            end
            default: ;
        endcase
    end

    trsp_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign tri_pop   = (state_reg == S_IDLE) && tri_valid;
    assign rec_valid = (state_reg == S_DONE);

    // Assemble the finished triangle
    always_comb begin
        logic signed [35:0] l36, v36, u36, n02x, n02y;
        l36  = $signed({4'd0, lu_reg});
        v36  = $signed({4'd0, vu_reg});
        u36  = uneg ? -$signed({4'd0, um_reg}) : $signed({4'd0, um_reg});
        n02x = degen ? v36 : -v36;
        n02y = degen ? -u36 : u36;
        rec.q_v      = qv_reg;
        rec.q_lu     = qlu_reg;
        rec.q_u      = qu_reg;
        rec.q_l      = ql_reg;
        rec.lu_neg   = lu_neg;
        rec.u_neg    = uneg;
        rec.det_f    = (|det_sh[63:31]) ? trsp_pkg::POS_LIMIT : det_sh[31:0];
        rec.area_f   = (|area_sh[63:31]) ? trsp_pkg::POS_LIMIT : area_sh[31:0];
        rec.share    = share_reg;
        rec.nrm_x[0] = half_sat(n02x);
        rec.nrm_y[0] = half_sat(n02y - l36);
        rec.nrm_x[1] = half_sat(v36);
        rec.nrm_y[1] = half_sat(-u36);
        rec.nrm_x[2] = half_sat(n02x + v36);
        rec.nrm_y[2] = half_sat(n02y + l36 - u36);
        rec.idx      = ent_reg.idx;
        rec.degen    = degen;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpa_reg <= '0;
        end else if (cfg_wr_en) begin
            mpa_reg <= cfg_wr_data;
        end
    end

    // Sequencer: state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            qsel_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (tri_valid) begin
                        ent_reg   <= tri_data;
                        lab2_reg  <= '0;
                        lac2_reg  <= '0;
                        dpos_reg  <= '0;
                        dneg_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_PROD;
                    end
                end
                S_PROD: begin
                    unique case (cnt_reg)
                        6'd1, 6'd2, 6'd3: lab2_reg <= lab2_reg + mul_p_reg;
                        6'd4, 6'd5, 6'd6: lac2_reg <= lac2_reg + mul_p_reg;
                        6'd7: if (ent_reg.dot_neg[0]) dneg_reg <= dneg_reg + mul_p_reg;
                              else dpos_reg <= dpos_reg + mul_p_reg;
                        6'd8: if (ent_reg.dot_neg[1]) dneg_reg <= dneg_reg + mul_p_reg;
                              else dpos_reg <= dpos_reg + mul_p_reg;
                        6'd9: if (ent_reg.dot_neg[2]) dneg_reg <= dneg_reg + mul_p_reg;
                              else dpos_reg <= dpos_reg + mul_p_reg;
                        default: ;
                    endcase
                    if (cnt_reg == 6'd9) begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQAB;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SQAB, S_SQAC, S_SQV: begin
                    if (cnt_reg == '0) begin
                        sq_op_reg  <= sq_src;
                        sq_res_reg <= '0;
                        sq_one_reg <= 64'h4000_0000_0000_0000;
                        cnt_reg    <= 6'd1;
                    end else begin
                        if (sq_ge) sq_op_reg <= sq_op_reg - sq_sum;
                        sq_res_reg <= sq_res_step;
                        sq_one_reg <= sq_one_reg >> 2;
                        if (cnt_reg == 6'd32) begin
                            cnt_reg <= '0;
                            unique case (state_reg)
                                S_SQAB: begin
                                    lu_reg    <= sq_res_step[31:0];
                                    state_reg <= S_SQAC;
                                end
                                S_SQAC: begin
                                    lc_reg    <= sq_res_step[31:0];
                                    state_reg <= S_USTART;
                                end
                                default: begin
                                    vu_reg    <= sq_res_step[31:0];
                                    state_reg <= S_DMUL;
                                end
                            endcase
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_USTART: begin
                    if (lu_reg == '0) begin
                        um_reg    <= '0;
                        state_reg <= S_UMUL;
                    end else begin
                        state_reg <= S_UWAIT;
                    end
                end
                S_UWAIT: begin
                    if (div_done) begin
                        um_reg <= ((|div_quo[DW-1:32]) || (div_quo[31:0] > lc_reg)) ?
                                  lc_reg : div_quo[31:0];
                        state_reg <= S_UMUL;
                    end
                end
                S_UMUL: begin
                    if (cnt_reg == 6'd1) begin
                        rad_reg   <= lac2_reg - mul_p_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_SQV;
                    end else begin
                        cnt_reg <= 6'd1;
                    end
                end
                S_DMUL: begin
                    if (cnt_reg == 6'd1) begin
                        det_reg    <= mul_p_reg;
                        sh_acc_reg <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= S_SMUL;
                    end else begin
                        cnt_reg <= 6'd1;
                    end
                end
                S_SMUL: begin
                    unique case (cnt_reg)
                        6'd1:    sh_acc_reg <= sh_acc_reg + 102'(mul_p_reg);
                        6'd2:    sh_acc_reg <= sh_acc_reg + {6'd0, mul_p_reg, 32'd0};
                        6'd3:    sh_acc_reg <= sh_acc_reg + {mul_p_reg[37:0], 64'd0};
                        default: ;
                    endcase
                    if (cnt_reg == 6'd3) begin
                        cnt_reg   <= '0;
                        state_reg <= S_SSTART;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SSTART: begin
                    qsel_reg <= '0;
                    if (sh_sat) begin
                        share_reg <= trsp_pkg::POS_LIMIT;
                        state_reg <= S_QSTART;
                    end else begin
                        state_reg <= S_SRCP;
                    end
                end
                // Divide the scaled area by 100 through four reciprocal partial products
                S_SRCP: begin
                    unique case (cnt_reg)
                        6'd1:    rcp_acc_reg <= 77'(mul_p_reg);
                        6'd2:    rcp_acc_reg <= rcp_acc_reg + {mul_p_reg[44:0], 32'd0};
                        6'd3:    rcp_acc_reg <= rcp_acc_reg + {mul_p_reg[44:0], 32'd0};
                        default: ;
                    endcase
                    if (cnt_reg == 6'd4) begin
                        share_reg <= rcp_q[31] ? trsp_pkg::POS_LIMIT : rcp_q;
                        cnt_reg   <= '0;
                        state_reg <= S_QSTART;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_QSTART, S_QWAIT: begin
                    logic [31:0] f;
                    logic        fin;
                    f   = '0;
                    fin = 1'b0;
                    if (state_reg == S_QSTART) begin
                        if (qmag == '0) begin
                            fin = 1'b1;
                        end else if (degen) begin
                            f   = trsp_pkg::NEG_LIMIT;
                            fin = 1'b1;
                        end else begin
                            state_reg <= S_QWAIT;
                        end
                    end else if (div_done) begin
                        f   = qsat;
                        fin = 1'b1;
                    end
                    if (fin) begin
                        unique case (qsel_reg)
                            2'd0:    qv_reg  <= f;
                            2'd1:    qlu_reg <= f;
                            2'd2:    qu_reg  <= f;
                            default: ql_reg  <= f;
                        endcase
                        qsel_reg  <= qsel_reg + 1'b1;
                        state_reg <= (qsel_reg == 2'd3) ? S_DONE : S_QSTART;
                    end
                end
                S_DONE: begin
                    if (rec_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/trsp_out.sv
module trsp_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rec_valid,
    input  trsp_pkg::trsp_rec_t rec,
    output logic                rec_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [143:0]        m_tdata,
    output logic [3:0]          m_tuser,
    output logic                m_tlast
);

    trsp_pkg::trsp_rec_t rec_reg;
    logic                have_reg;
    logic [2:0]          beat_reg;
    logic                last_beat;

    // Signed quotient from a saturated magnitude
    function automatic logic [31:0] sgnq(input logic neg, input logic [31:0] f);
        if (neg) return 32'(32'd0 - f);
        else     return (f == trsp_pkg::NEG_LIMIT) ? trsp_pkg::POS_LIMIT : f;
    endfunction

    assign last_beat = (beat_reg == trsp_pkg::SLOT_CORNER_C);
    assign rec_ready = !have_reg || (m_tready && last_beat);
    assign m_tvalid  = have_reg;
    assign m_tlast   = last_beat;
    assign m_tuser   = {rec_reg.degen, beat_reg};

    // Select the fields of the current beat
    always_comb begin
        m_tdata = '0;
        unique case (beat_reg)
            trsp_pkg::SLOT_INV: begin
                m_tdata[47:16]   = sgnq(1'b0, rec_reg.q_v);
                m_tdata[79:48]   = sgnq(rec_reg.lu_neg, rec_reg.q_lu);
                m_tdata[111:80]  = sgnq(1'b1, rec_reg.q_v);
                m_tdata[143:112] = sgnq(rec_reg.u_neg, rec_reg.q_u);
            end
            trsp_pkg::SLOT_COEF_LO: begin
                m_tdata[47:16]   = sgnq(1'b1, rec_reg.q_v);
                m_tdata[79:48]   = sgnq(!rec_reg.lu_neg, rec_reg.q_lu);
                m_tdata[111:80]  = sgnq(1'b0, rec_reg.q_v);
                m_tdata[143:112] = sgnq(!rec_reg.u_neg, rec_reg.q_u);
            end
            trsp_pkg::SLOT_COEF_HI: begin
                m_tdata[79:48]   = sgnq(1'b0, rec_reg.q_l);
                m_tdata[111:80]  = rec_reg.det_f;
                m_tdata[143:112] = rec_reg.area_f;
            end
            trsp_pkg::SLOT_CORNER_A: begin
                m_tdata[15:0]    = rec_reg.idx[0];
                m_tdata[47:16]   = rec_reg.share;
                m_tdata[79:48]   = rec_reg.nrm_x[0];
                m_tdata[111:80]  = rec_reg.nrm_y[0];
            end
            trsp_pkg::SLOT_CORNER_B: begin
                m_tdata[15:0]    = rec_reg.idx[1];
                m_tdata[47:16]   = rec_reg.share;
                m_tdata[79:48]   = rec_reg.nrm_x[1];
                m_tdata[111:80]  = rec_reg.nrm_y[1];
            end
            trsp_pkg::SLOT_CORNER_C: begin
                m_tdata[15:0]    = rec_reg.idx[2];
                m_tdata[47:16]   = rec_reg.share;
                m_tdata[79:48]   = rec_reg.nrm_x[2];
                m_tdata[111:80]  = rec_reg.nrm_y[2];
            end
            default: ;
        endcase
    end

    // Load a finished triangle, advance one beat per handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
            beat_reg <= trsp_pkg::SLOT_INV;
        end else if (rec_valid && rec_ready) begin
            have_reg <= 1'b1;
            beat_reg <= trsp_pkg::SLOT_INV;
        end else if (have_reg && m_tready) begin
            if (last_beat) have_reg <= 1'b0;
            else           beat_reg <= beat_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_valid && rec_ready) begin
            rec_reg <= rec;
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] crd [9];   // a_x a_y a_z b_x b_y b_z c_x c_y c_z
        logic [15:0]        idx [3];
    } tri_t;

    typedef struct {
        logic [2:0]  slot;
        logic [15:0] vidx;
        logic [31:0] v0, v1, v2, v3;
        logic        degen;
        logic        last;
    } rest_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [335:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    tri_t       tri_q [$];
    rest_beat_t rest_q [$];
    tri_t       offered;
    logic [31:0] mass_cfg = '0;
    int n_pushed = 0;
    int n_accepted = 0;
    int n_beats = 0;
    int n_errors = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int rx_hold = 0;
    bit rx_hold_done = 0;

    triangle_rest_shape_precompute_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor square root, two bits per step
    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] op, res, one;
        op = x;
        res = 0;
        one = 64'd1 << 62;
        while (one > op) one >>= 2;
        while (one != 0) begin
            if (op >= res + one) begin
                op -= res + one;
                res = (res >> 1) + one;
            end else begin
                res >>= 1;
            end
            one >>= 2;
        end
        return res;
    endfunction

    // signed numerator over det with 32 fraction bits, truncate then saturate
    function automatic logic [31:0] over_det(longint num, logic [63:0] det);
        logic [127:0] q;
        logic [63:0]  mag, cap;
        bit neg;
        neg = num < 0;
        mag = neg ? 64'(-num) : 64'(num);
        if (mag == 0) return '0;
        cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (det == 0) begin
            q = 128'(cap);
        end else begin
            q = ({64'd0, mag} << 32) / {64'd0, det};
            if (q > 128'(cap)) q = 128'(cap);
        end
        return neg ? 32'(64'd0 - q[63:0]) : q[31:0];
    endfunction

    function automatic logic [31:0] cap_pos(logic [63:0] v);
        return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

    // flatten the triangle and queue its six result beats
    task automatic predict_rest_shape(tri_t t);
        longint d [3], e [3];
        longint lv, vv, uv, n02x, n02y;
        logic [63:0] md, me, lab2, lac2, dp, dn, lu, lc, um, vu, det;
        logic [127:0] w;
        logic [31:0] share;
        bit uneg, degen;
        rest_beat_t b;
        lab2 = 0; lac2 = 0; dp = 0; dn = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = clip32(longint'(t.crd[3+i]) - longint'(t.crd[i]));
            e[i] = clip32(longint'(t.crd[6+i]) - longint'(t.crd[i]));
            md = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
            me = (e[i] < 0) ? 64'(-e[i]) : 64'(e[i]);
            lab2 += md * md;
            lac2 += me * me;
            if ((d[i] < 0) != (e[i] < 0)) dn += md * me;
            else dp += md * me;
        end
        lu = floor_root(lab2);
        lc = floor_root(lac2);
        uneg = dn > dp;
        um = 0;
        if (lu != 0) um = (uneg ? dn - dp : dp - dn) / lu;
        // rounding can push |U| past |AC|
        if (um > lc) um = lc;
        vu = floor_root(lac2 - um * um);
        det = lu * vu;
        degen = (det == 0);
        lv = longint'(lu);
        vv = longint'(vu);
        uv = uneg ? -longint'(um) : longint'(um);

        b.degen = degen;
        b.last = 1'b0;
        b.vidx = '0;
        b.slot = trsp_pkg::SLOT_INV;
        b.v0 = over_det(vv, det);
        b.v1 = over_det(lv - uv, det);
        b.v2 = over_det(-vv, det);
        b.v3 = over_det(uv, det);
        rest_q.insert(rest_q.size(), b);
        b.slot = trsp_pkg::SLOT_COEF_LO;
        b.v0 = over_det(-vv, det);
        b.v1 = over_det(uv - lv, det);
        b.v2 = over_det(vv, det);
        b.v3 = over_det(-uv, det);
        rest_q.insert(rest_q.size(), b);
        b.slot = trsp_pkg::SLOT_COEF_HI;
        b.v0 = '0;
        b.v1 = over_det(lv, det);
        b.v2 = cap_pos(det >> 16);
        b.v3 = cap_pos(det >> 17);
        rest_q.insert(rest_q.size(), b);

        w = (128'(mass_cfg) * 128'd33) * 128'(det);
        w = (w >> 33) / 128'd100;
        share = (w > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : w[31:0];

        n02x = degen ? vv : -vv;
        n02y = degen ? -uv : uv;
        b.v0 = share;
        b.v3 = '0;
        b.slot = trsp_pkg::SLOT_CORNER_A;
        b.vidx = t.idx[0];
        b.v1 = 32'(clip32(n02x / 2));
        b.v2 = 32'(clip32((n02y - lv) / 2));
        rest_q.insert(rest_q.size(), b);
        b.slot = trsp_pkg::SLOT_CORNER_B;
        b.vidx = t.idx[1];
        b.v1 = 32'(clip32(vv / 2));
        b.v2 = 32'(clip32(-uv / 2));
        rest_q.insert(rest_q.size(), b);
        b.slot = trsp_pkg::SLOT_CORNER_C;
        b.vidx = t.idx[2];
        b.last = 1'b1;
        b.v1 = 32'(clip32((n02x + vv) / 2));
        b.v2 = 32'(clip32((n02y + lv - uv) / 2));
        rest_q.insert(rest_q.size(), b);
    endtask

    function automatic logic [335:0] pack_tri(tri_t t);
        logic [335:0] p;
        for (int i = 0; i < 9; i++) p[32*i +: 32] = t.crd[i];
        for (int i = 0; i < 3; i++) p[288 + 16*i +: 16] = t.idx[i];
        return p;
    endfunction

    function automatic int draw_gap(int count);
        // every fourth stretch of eight runs without idling
        if ((count / 8) % 4 == 1) return 0;
        return $urandom_range(0, 5);
    endfunction

    // drive triangles from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_rest_shape(offered);
                n_accepted++;
                tx_wait = draw_gap(n_accepted);
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat
            end else if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end else if (tri_q.size() > 0) begin
                offered = tri_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= pack_tri(offered);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // check result beats and throttle the result side
    always @(posedge aclk) begin
        rest_beat_t b;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_beats++;
                if (rest_q.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    n_errors++;
                end else begin
                    b = rest_q.pop_front();
                    check_field("slot", 32'(b.slot), 32'(m_tuser[2:0]));
                    check_field("vertex_index", 32'(b.vidx), 32'(m_tdata[15:0]));
                    check_field("value0", b.v0, m_tdata[47:16]);
                    check_field("value1", b.v1, m_tdata[79:48]);
                    check_field("value2", b.v2, m_tdata[111:80]);
                    check_field("value3", b.v3, m_tdata[143:112]);
                    check_field("degenerate", 32'(b.degen), 32'(m_tuser[3]));
                    check_field("last", 32'(b.last), 32'(m_tlast));
                end
                rx_wait = draw_gap(n_beats);
            end
            if (!rx_hold_done && n_accepted >= 40) begin
                rx_hold = 3000;
                rx_hold_done = 1;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_tri(logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz,
                           logic [15:0] ia, ib, ic);
        tri_t t;
        t.crd = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        t.idx = '{ia, ib, ic};
        tri_q.insert(tri_q.size(), t);
        n_pushed++;
    endtask

    function automatic logic signed [31:0] rnd_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
            default: return $signed($urandom() >> $urandom_range(1, 31))
                            * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    // mostly real triangles around a random center, some noise
    task automatic add_random_tri();
        tri_t t;
        int shape;
        logic signed [31:0] base;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            if (shape < 2) begin
                t.crd[i] = rnd_coord(0);
            end else if (shape < 4) begin
                t.crd[i] = rnd_coord(2);
            end else begin
                base = (i < 3) ? rnd_coord(2) >>> 2 : t.crd[i % 3];
                t.crd[i] = (i < 3) ? base : base + rnd_coord(1);
            end
        end
        // collinear or repeated corners now and then
        if (shape == 9) begin
            for (int i = 0; i < 3; i++) t.crd[6+i] = 2 * t.crd[3+i] - t.crd[i];
        end
        for (int i = 0; i < 3; i++) t.idx[i] = $urandom();
        tri_q.insert(tri_q.size(), t);
        n_pushed++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (n_accepted != n_pushed || rest_q.size() != 0);
        repeat (700) @(negedge aclk);
    endtask

    task automatic write_mass(logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        mass_cfg = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MN = 32'sh8000_0000;

    initial begin
        logic [31:0] masses [4];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_mass(32'hFFFF_FFFF);

        // directed triangles
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
        add_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 16'd1, 16'd2, 16'd3);
        add_tri(0, 0, 0, ONE, 0, 0, -ONE, ONE, 0, 16'd4, 16'd5, 16'd6);
        add_tri(0, 0, 0, ONE, 0, 0, 3*ONE, ONE, ONE, 16'd7, 16'd8, 16'd9);
        add_tri(0, 0, 0, ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, 16'd10, 16'd11, 16'd12);
        add_tri(0, 0, 0, 3, 5, 7, 6, 10, 14, 16'd13, 16'd14, 16'd15);
        add_tri(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 0, ONE, 0, 16'd16, 16'd17, 16'd18);
        add_tri(MN, MN, MN, MX, MX, MX, MX, MN, MX, 16'hFFFF, 16'h0000, 16'h8000);
        add_tri(MX, MX, MX, MN, MN, MN, MN, MX, MN, 16'h0000, 16'hFFFF, 16'h7FFF);
        add_tri(MN, MX, 0, MX, MN, 0, 0, 0, MX, 16'h5555, 16'hAAAA, 16'h00FF);
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 16'd19, 16'd20, 16'd21);
        add_tri(0, 0, 0, 32'sh4000_0000, 0, 0, 0, 32'sh4000_0000, 0, 16'd22, 16'd23, 16'd24);
        add_tri(-ONE, -ONE, -ONE, -2*ONE, -ONE, ONE, ONE, -3*ONE, 2*ONE, 16'd25, 16'd26,
                16'd27);
        wait_idle();

        // random triangles over several register settings
        masses = '{32'h0000_0000, $urandom(), 32'h0001_0000, 32'h0000_0001};
        for (int p = 0; p < 4; p++) begin
            write_mass(masses[p]);
            for (int k = 0; k < 40; k++) add_random_tri();
            wait_idle();
        end

        if (n_errors == 0 && rest_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            if (rest_q.size() != 0) $error("%0d result beats never arrived", rest_q.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // stop a hung run
    initial begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
